// File: rtl/core/qn_pkg.sv
// Package: widths, payload structs and pipeline sideband types for the quaternion normaliser.
package qn_pkg;

  localparam int CW    = 16;
  localparam int FB    = 14;
  localparam int TOL_W = 16;
  localparam int SW    = 2 * CW + 1;
  localparam int RW    = CW + 1;
  localparam int XW    = 2 * RW;
  localparam int NDW   = CW + FB + 2;
  localparam int DW    = CW + 2;
  localparam int LANES = 4;

  typedef struct packed {
    logic signed [CW-1:0] w_in;
    logic signed [CW-1:0] x_in;
    logic signed [CW-1:0] y_in;
    logic signed [CW-1:0] z_in;
  } in_t;

  typedef struct packed {
    logic        [CW-1:0] norm_out;
    logic signed [CW-1:0] w_out;
    logic signed [CW-1:0] x_out;
    logic signed [CW-1:0] y_out;
    logic signed [CW-1:0] z_out;
    logic                 on_sphere;
    logic                 zero_input;
  } out_t;

  typedef struct packed {
    logic [LANES-1:0][CW-1:0] mag;
    logic [LANES-1:0]         neg;
    logic                     zero;
    logic                     on_sphere;
  } side_t;

  typedef struct packed {
    logic [RW-1:0]    norm;
    logic [LANES-1:0] neg;
    logic             zero;
    logic             on_sphere;
  } tail_t;

endpackage

// File: rtl/core/qn_square.sv
// One component lane: magnitude, sign and registered square.
module qn_square (
  input  logic                 clk,
  input  logic                 en,
  input  logic [qn_pkg::CW-1:0]   comp,
  output logic [qn_pkg::CW-1:0]   mag,
  output logic                 neg,
  output logic [2*qn_pkg::CW-1:0] sq
);
  import qn_pkg::*;

  logic [CW-1:0] mag_c;

  always_comb begin
    mag_c = comp[CW-1] ? (~comp + 1'b1) : comp;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mag <= mag_c;
      neg <= comp[CW-1];
      sq  <= (2*CW)'(mag_c) * (2*CW)'(mag_c);
    end
  end
endmodule

// File: rtl/core/qn_sqrt.sv
// Pipelined restoring square root, one root bit per stage, with remainder.
module qn_sqrt (
  input  logic                 clk,
  input  logic                 en,
  input  logic [qn_pkg::XW-1:0]   x,
  output logic [qn_pkg::RW-1:0]   root,
  output logic [qn_pkg::RW+1:0]   rem
);
  import qn_pkg::*;

  logic [XW-1:0] x_s    [RW+1];
  logic [RW+1:0] rem_s  [RW+1];
  logic [RW-1:0] root_s [RW+1];

  assign x_s[0]    = x;
  assign rem_s[0]  = '0;
  assign root_s[0] = '0;

  for (genvar j = 0; j < RW; j++) begin : g_stage
    logic [RW+3:0] t;
    logic [RW+3:0] trial;
    logic          ge;

    always_comb begin
      t     = {rem_s[j], x_s[j][XW-1:XW-2]};
      trial = {2'b00, root_s[j], 2'b01};
      ge    = (t >= trial);
    end

    always_ff @(posedge clk) begin
      if (en) begin
        x_s[j+1]    <= {x_s[j][XW-3:0], 2'b00};
        rem_s[j+1]  <= ge ? (RW+2)'(t - trial) : (RW+2)'(t);
        root_s[j+1] <= {root_s[j][RW-2:0], ge};
      end
    end
  end

  assign root = root_s[RW];
  assign rem  = rem_s[RW];
endmodule

// File: rtl/core/qn_divide.sv
// One divider lane: pipelined restoring division, one quotient bit per stage.
module qn_divide (
  input  logic                 clk,
  input  logic                 en,
  input  logic [qn_pkg::NDW-1:0]  num,
  input  logic [qn_pkg::DW-1:0]   den,
  output logic [qn_pkg::NDW-1:0]  quo
);
  import qn_pkg::*;

  logic [NDW-1:0] num_s [NDW+1];
  logic [DW-1:0]  den_s [NDW+1];
  logic [DW-1:0]  rem_s [NDW+1];
  logic [NDW-1:0] quo_s [NDW+1];

  assign num_s[0] = num;
  assign den_s[0] = den;
  assign rem_s[0] = '0;
  assign quo_s[0] = '0;

  for (genvar j = 0; j < NDW; j++) begin : g_stage
    logic [DW:0] t;
    logic        ge;

    always_comb begin
      t  = {rem_s[j], num_s[j][NDW-1]};
      ge = (t >= {1'b0, den_s[j]});
    end

    always_ff @(posedge clk) begin
      if (en) begin
        num_s[j+1] <= {num_s[j][NDW-2:0], 1'b0};
        den_s[j+1] <= den_s[j];
        rem_s[j+1] <= ge ? DW'(t - {1'b0, den_s[j]}) : DW'(t);
        quo_s[j+1] <= {quo_s[j][NDW-2:0], ge};
      end
    end
  end

  assign quo = quo_s[NDW];
endmodule

// File: rtl/core/quaternion_normalizer_top.sv
// Quaternion normaliser top level: input stage, square lanes, root, divider lanes, merge.
//
// Channels: in_valid/in_ready/in_data carries one quaternion (four Q1.14
// components) per beat; out_valid/out_ready/out_data carries one result
// beat per input beat: rounded norm, four normalised components, on_sphere
// and zero_input flags. cfg_valid/cfg_ready/cfg_data writes sphere_tolerance;
// cfg_ready is always high.
// Pipeline: 55 register stages (input, square, sum, 17 root stages, rounding,
// divider set-up, 32 divider stages, output register).
// Throughput: one beat per cycle; a new beat is taken every cycle while
// the output register is empty or being drained.
// Pipeline depth is set by the bit-serial root (one bit per stage) and the
// four divider lanes (one quotient bit per stage).
// Reset clears all stage valids and sets the tolerance to zero.
// When the receiver stalls with a result waiting, the whole pipe holds and
// in_ready drops until the result beat is taken.
module quaternion_normalizer_top (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  qn_pkg::in_t             in_data,
  output logic                    out_valid,
  input  logic                    out_ready,
  output qn_pkg::out_t            out_data,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [qn_pkg::TOL_W-1:0] cfg_data
);
  import qn_pkg::*;

  localparam int LAT = RW + NDW + 6;
  localparam logic [SW-1:0] ONE  = SW'(1) << (2 * FB);
  localparam logic [CW-1:0] HALF = CW'(1) << (CW - 1);
  localparam logic [CW-1:0] SMAX = HALF - CW'(1);
  localparam logic [CW-1:0] CMAX = '1;

  logic             en;
  logic [LAT-1:0]   vld;
  logic [TOL_W-1:0] tolerance;
  in_t              in_q;

  logic [LANES-1:0][CW-1:0]   comp_a;
  logic [LANES-1:0][CW-1:0]   mag_a;
  logic [LANES-1:0]           neg_a;
  logic [2*CW-1:0]            sq_a [LANES];

  logic [SW-1:0] sum_q;
  side_t         side3;
  side_t         side3_c;
  side_t         side_d [RW];
  logic [RW-1:0] root;
  logic [RW+1:0] rem;

  logic [RW-1:0]  norm_q;
  side_t          side_r;
  logic [NDW-1:0] num_q [LANES];
  logic [DW-1:0]  den_q;
  tail_t          tail_p;
  tail_t          tail_d [NDW];
  logic [NDW-1:0] quo_a  [LANES];
  logic [LANES-1:0][CW-1:0] res_a;

  assign en        = !out_valid || out_ready;
  assign in_ready  = en;
  assign out_valid = vld[LAT-1];
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      tolerance <= '0;
    end else begin
      if (en) vld <= {vld[LAT-2:0], in_valid};
      if (cfg_valid) tolerance <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (en) in_q <= in_data;
  end

  assign comp_a[0] = in_q.w_in;
  assign comp_a[1] = in_q.x_in;
  assign comp_a[2] = in_q.y_in;
  assign comp_a[3] = in_q.z_in;

  for (genvar i = 0; i < LANES; i++) begin : g_sq
    qn_square u_sq (
      .clk  (clk),
      .en   (en),
      .comp (comp_a[i]),
      .mag  (mag_a[i]),
      .neg  (neg_a[i]),
      .sq   (sq_a[i])
    );
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sum_q <= SW'(sq_a[0]) + SW'(sq_a[1]) + SW'(sq_a[2]) + SW'(sq_a[3]);
      side3.mag       <= mag_a;
      side3.neg       <= neg_a;
      side3.zero      <= (mag_a == '0);
      side3.on_sphere <= 1'b0;
    end
  end

  always_comb begin
    side3_c = side3;
    if (sum_q >= ONE) side3_c.on_sphere = ((sum_q - ONE) <= SW'(tolerance));
    else              side3_c.on_sphere = ((ONE - sum_q) <= SW'(tolerance));
  end

  qn_sqrt u_sqrt (
    .clk  (clk),
    .en   (en),
    .x    (XW'(sum_q)),
    .root (root),
    .rem  (rem)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      side_d[0] <= side3_c;
      for (int k = 1; k < RW; k++) side_d[k] <= side_d[k-1];
      norm_q <= root + RW'(rem > (RW+2)'(root));
      side_r <= side_d[RW-1];
      for (int i = 0; i < LANES; i++)
        num_q[i] <= (NDW'(side_r.mag[i]) << (FB + 1)) + NDW'(norm_q);
      den_q            <= DW'(norm_q) << 1;
      tail_p.norm      <= norm_q;
      tail_p.neg       <= side_r.neg;
      tail_p.zero      <= side_r.zero;
      tail_p.on_sphere <= side_r.on_sphere;
      tail_d[0] <= tail_p;
      for (int k = 1; k < NDW; k++) tail_d[k] <= tail_d[k-1];
    end
  end

  for (genvar i = 0; i < LANES; i++) begin : g_div
    logic [CW-1:0] qc;

    qn_divide u_div (
      .clk (clk),
      .en  (en),
      .num (num_q[i]),
      .den (den_q),
      .quo (quo_a[i])
    );

    always_comb begin
      qc = (quo_a[i] > NDW'(HALF)) ? HALF : quo_a[i][CW-1:0];
      if (tail_d[NDW-1].zero)          res_a[i] = '0;
      else if (tail_d[NDW-1].neg[i])   res_a[i] = ~qc + 1'b1;
      else if (qc == HALF)             res_a[i] = SMAX;
      else                             res_a[i] = qc;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data.w_out      <= res_a[0];
      out_data.x_out      <= res_a[1];
      out_data.y_out      <= res_a[2];
      out_data.z_out      <= res_a[3];
      out_data.on_sphere  <= tail_d[NDW-1].on_sphere;
      out_data.zero_input <= tail_d[NDW-1].zero;
      if (tail_d[NDW-1].zero)                   out_data.norm_out <= '0;
      else if (tail_d[NDW-1].norm > RW'(CMAX))  out_data.norm_out <= CMAX;
      else                                      out_data.norm_out <= tail_d[NDW-1].norm[CW-1:0];
    end
  end
endmodule

// File: rtl/core/qn_checker.sv
// Port-level checker for the quaternion normaliser, bound to the top level.
module qn_checker (
  input logic         clk,
  input logic         rst,
  input logic         in_ready,
  input logic         out_valid,
  input logic         out_ready,
  input qn_pkg::out_t out_data
);
  import qn_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  a_stall: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while output stalled");

  a_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.zero_input |->
      out_data.norm_out == '0 && out_data.w_out == '0 && out_data.x_out == '0 &&
      out_data.y_out == '0 && out_data.z_out == '0)
    else $error("zero input gave non-zero result");

  a_norm: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.zero_input |-> out_data.norm_out != '0)
    else $error("non-zero input gave zero norm");

  a_rst: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");
endmodule

bind quaternion_normalizer_top qn_checker u_qn_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// File: tb/quaternion_normalizer_top_test.sv
// Self-checking testbench for the quaternion normaliser: random and corner quaternions, tolerance sweep.
`timescale 1ns / 1ps

module quaternion_normalizer_top_test;
  import qn_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 80;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [TOL_W-1:0] cfg_data = '0;

  in_t quat_queue[$];
  out_t result_queue[$];
  logic [TOL_W-1:0] tolerance = '0;
  int errors = 0;
  int cycles = 0;
  int send_gap = 0;
  int recv_gap = 0;
  int hold_off = 0;
  bit sender_pause = 1'b0;

  quaternion_normalizer_top uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic out_t normalise(in_t q, logic [TOL_W-1:0] tol);
    out_t r;
    logic signed [CW-1:0] c[4];
    longint unsigned mag[4];
    longint unsigned sum, root, rem, diff, num, qm, one;
    longint signed qs;
    bit zero;
    r = '0;
    c[0] = q.w_in; c[1] = q.x_in; c[2] = q.y_in; c[3] = q.z_in;
    sum = 0;
    zero = 1'b1;
    for (int i = 0; i < 4; i++) begin
      mag[i] = (c[i] < 0) ? longint'(-longint'(c[i])) : longint'(c[i]);
      if (mag[i] != 0) zero = 1'b0;
      sum += mag[i] * mag[i];
    end
    root = 0;
    for (int b = 31; b >= 0; b--) begin
      longint unsigned t;
      t = root | (64'd1 << b);
      if (t * t <= sum) root = t;
    end
    rem = sum - root * root;
    if (rem > root) root++;
    one = 64'd1 << (2 * FB);
    diff = (sum >= one) ? sum - one : one - sum;
    r.on_sphere = (diff <= tol);
    r.zero_input = zero;
    r.norm_out = zero ? '0 : ((root > 64'hFFFF) ? 16'hFFFF : root[CW-1:0]);
    for (int i = 0; i < 4; i++) begin
      qs = 0;
      if (!zero) begin
        num = (mag[i] << FB) * 2 + root;
        qm = num / (root * 2);
        if (qm > 32768) qm = 32768;
        qs = (c[i] < 0) ? -longint'(qm) : longint'(qm);
        if (qs > 32767) qs = 32767;
        if (qs < -32768) qs = -32768;
      end
      case (i)
        0: r.w_out = qs[CW-1:0];
        1: r.x_out = qs[CW-1:0];
        2: r.y_out = qs[CW-1:0];
        default: r.z_out = qs[CW-1:0];
      endcase
    end
    return r;
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_ready) begin
    end else if (send_gap > 0 || sender_pause || quat_queue.size() == 0) begin
      if (in_valid) begin
        result_queue.push_back(normalise(in_data, tolerance));
      end
      in_valid <= 1'b0;
      if (send_gap > 0) send_gap <= send_gap - 1;
    end else begin
      if (in_valid) begin
        result_queue.push_back(normalise(in_data, tolerance));
      end
      in_data <= quat_queue.pop_front();
      in_valid <= 1'b1;
      send_gap <= ($urandom_range(3) == 0) ? 0 : $urandom_range(11);
    end
  end

  // receiver
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (result_queue.size() == 0) begin
          $display("%0t unexpected beat %h", $time, out_data);
          errors++;
        end else begin
          out_t e;
          e = result_queue.pop_front();
          if (e.norm_out !== out_data.norm_out)
            $display("%0t norm exp %h got %h", $time, e.norm_out, out_data.norm_out);
          if (e.w_out !== out_data.w_out)
            $display("%0t w exp %h got %h", $time, e.w_out, out_data.w_out);
          if (e.x_out !== out_data.x_out)
            $display("%0t x exp %h got %h", $time, e.x_out, out_data.x_out);
          if (e.y_out !== out_data.y_out)
            $display("%0t y exp %h got %h", $time, e.y_out, out_data.y_out);
          if (e.z_out !== out_data.z_out)
            $display("%0t z exp %h got %h", $time, e.z_out, out_data.z_out);
          if (e.on_sphere !== out_data.on_sphere)
            $display("%0t on_sphere exp %b got %b", $time, e.on_sphere, out_data.on_sphere);
          if (e.zero_input !== out_data.zero_input)
            $display("%0t zero exp %b got %b", $time, e.zero_input, out_data.zero_input);
          if (e !== out_data) errors++;
        end
      end
      if (hold_off > 0) begin
        hold_off <= hold_off - 1;
        out_ready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (out_valid && out_ready)
          recv_gap <= ($urandom_range(3) == 0) ? 0 : $urandom_range(11);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic logic signed [CW-1:0] rand_comp();
    case ($urandom_range(5))
      0: return 16'sh8000;
      1: return 16'sh7FFF;
      2: return CW'($urandom_range(16384) - 8192);
      3: return 16'sd0;
      default: return CW'($urandom);
    endcase
  endfunction

  task automatic push_quat(logic signed [CW-1:0] w, x, y, z);
    in_t q;
    q.w_in = w; q.x_in = x; q.y_in = y; q.z_in = z;
    quat_queue.push_back(q);
  endtask

  task automatic wait_idle();
    while (quat_queue.size() != 0 || in_valid || result_queue.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_tolerance(logic [TOL_W-1:0] t);
    cfg_data <= t;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    tolerance = t;
  endtask

  task automatic random_batch(int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(4) == 0)
        push_quat(CW'(16384 + $urandom_range(8) - 4), 0, 0, 0);
      else
        push_quat(rand_comp(), rand_comp(), rand_comp(), rand_comp());
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    push_quat(0, 0, 0, 0);
    push_quat(16384, 0, 0, 0);
    push_quat(0, -16384, 0, 0);
    push_quat(0, 0, 16384, 0);
    push_quat(0, 0, 0, -16384);
    push_quat(8192, 8192, 8192, 8192);
    push_quat(-8192, 8192, -8192, 8192);
    push_quat(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
    push_quat(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
    push_quat(16'sh8000, 0, 0, 0);
    push_quat(1, 0, 0, 0);
    push_quat(-1, 0, 0, 0);
    push_quat(1, 1, -1, 1);
    push_quat(16385, 0, 0, 0);
    push_quat(16383, 0, 0, 0);
    push_quat(16'sh7FFF, 16'sh8000, 1, -1);
    push_quat(11585, 11585, 0, 0);
    wait_idle();
    set_tolerance(16'hFFFF);
    random_batch(200);
    wait_idle();
    set_tolerance(16'd1000);
    hold_off = 150;
    random_batch(250);
    wait_idle();
    set_tolerance(16'd0);
    random_batch(200);
    sender_pause = 1'b1;
    while (in_valid || result_queue.size() != 0) @(posedge clk);
    sender_pause = 1'b0;
    random_batch(100);
    wait_idle();
    set_tolerance(TOL_W'($urandom));
    random_batch(150);
    wait_idle();
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
